// File: hdl/uebip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uebip_pkg
// Types and codes shared by the boot EEPROM image parser and its result queue.
// ----------------------------------------------------------------------------
package uebip_pkg;

  // Largest image the parser will bound its checks against.
  localparam int unsigned MaxImageBytes = 65536;

  // Depth of the result queue; must be a power of two and at least 2.
  localparam int unsigned ResDepth = 4;

  // Image type bytes.
  localparam logic [7:0] TypeC0 = 8'hC0;
  localparam logic [7:0] TypeC2 = 8'hC2;

  // Segment count word: last-segment flag and reserved bits.
  localparam logic [15:0] CntLastMask = 16'h8000;
  localparam logic [15:0] CntRsvdMask = 16'h6C00;

  // Header length and the segment header length in bytes.
  localparam int unsigned HdrBytes = 8;
  localparam int unsigned SegHdrBytes = 4;

  // Parse phases.
  localparam logic [2:0] PhType    = 3'd0;
  localparam logic [2:0] PhHdrC0   = 3'd1;
  localparam logic [2:0] PhHdrC2   = 3'd2;
  localparam logic [2:0] PhCntHi   = 3'd3;
  localparam logic [2:0] PhCntLo   = 3'd4;
  localparam logic [2:0] PhAdrHi   = 3'd5;
  localparam logic [2:0] PhAdrLo   = 3'd6;
  localparam logic [2:0] PhPayload = 3'd7;

  // Result kinds.
  typedef enum logic [1:0] {
    KindHeader  = 2'd0,
    KindSegment = 2'd1,
    KindPayload = 2'd2,
    KindStatus  = 2'd3
  } kind_e;

  // Status codes.
  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StHeaderOnly = 3'd1,
    StBadType    = 3'd2,
    StPastImage  = 3'd3,
    StRsvdBits   = 3'd4,
    StOverrun    = 3'd5,
    StShortImage = 3'd6
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] address;
    logic [7:0]  value;
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [15:0] device_id;
    logic [12:0] segment_length;
    logic        final_segment;
    status_e     status;
    logic        end_of_run;
  } result_t;

endpackage

// File: hdl/uebip_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uebip_res_fifo
// Small result queue: takes up to two result words per cycle, gives one.
// ----------------------------------------------------------------------------
module uebip_res_fifo #(
  parameter int unsigned Depth = uebip_pkg::ResDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        wr_cnt_i,
  input  uebip_pkg::result_t wr_data0_i,
  input  uebip_pkg::result_t wr_data1_i,
  output logic              room_o,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output uebip_pkg::result_t rd_data_o
);
  import uebip_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  // Room for two words regardless of what is read this cycle.
  assign room_o     = (count_q <= CntW'(Depth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(wr_cnt_i);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(wr_cnt_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_data0_i;
    end
    if (wr_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= wr_data1_i;
    end
  end

endmodule

// File: hdl/usb_boot_eeprom_image_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_boot_eeprom_image_parser
// Streaming parser for C0/C2 boot EEPROM images, one image byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   Image bytes enter on the in channel (valid/ready), one byte per word.
//   first_byte_i marks offset zero and restarts parsing at any time. Bytes
//   that arrive after parsing has finished, or before any first byte, are
//   taken and dropped.
//   image_size_i is written with image_size_we_i; the user does so only
//   while the block is idle, which the block itself does not enforce.
//   Results leave on the out channel (valid/ready), one result per word:
//   header, segment descriptor, payload write or final status. A byte gives
//   zero, one or two results; end_of_run_o flags the last one of a byte.
//   A byte taken is held in the input register, parsed from there, and its
//   results are written into the result queue, which offers them.
//   Throughput: one byte per cycle while the queue has room. The result port
//   moves one word per cycle, so bytes giving two results (header, segment
//   or payload plus status) wait in the four-entry result queue.
//   When the receiver stalls the queue fills, the input register holds its
//   byte and in_ready_o drops; nothing is lost.
//   Reset clears the queue and leaves the parser finished, waiting for a
//   first byte; the image size resets to zero.
// ----------------------------------------------------------------------------
module usb_boot_eeprom_image_parser #(
  parameter int unsigned MAX_IMAGE_BYTES = uebip_pkg::MaxImageBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        image_size_we_i,
  input  logic [16:0] image_size_i,
  // Image bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  // Results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [15:0] address_o,
  output logic [7:0]  value_o,
  output logic [15:0] vendor_id_o,
  output logic [15:0] product_id_o,
  output logic [15:0] device_id_o,
  output logic [12:0] segment_length_o,
  output logic        final_segment_o,
  output logic [2:0]  status_o,
  output logic        end_of_run_o
);
  import uebip_pkg::*;

  localparam logic [16:0] MaxSize = 17'(MAX_IMAGE_BYTES);

  // Configuration register.
  logic [16:0] image_size_q;

  // Input register.
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_first_q;

  // Parser state.
  logic [16:0] pos_q, pos_d;
  logic [2:0]  phase_q, phase_d;
  logic [15:0] vendor_q, vendor_d;
  logic [15:0] product_q, product_d;
  logic [15:0] device_q, device_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] seg_addr_q, seg_addr_d;
  logic [12:0] left_q, left_d;
  logic        last_q, last_d;
  logic        finished_q, finished_d;

  // Results of the byte in the input register.
  result_t     res0, res1, rd_data;
  logic [1:0]  res_cnt;
  logic        room;
  logic        proc;

  assign proc       = s1_valid_q && room;
  assign in_ready_o = !s1_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= '0;
    end else if (image_size_we_i) begin
      image_size_q <= image_size_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q  <= data_byte_i;
      s1_first_q <= first_byte_i;
    end
  end

  // Parse step. A step gives at most one header, descriptor or payload
  // word, optionally followed by a status word that ends the parse.
  always_comb begin
    logic [16:0] size;
    logic [16:0] e_pos;
    logic [2:0]  e_phase;
    logic        e_last, e_fin;
    logic [12:0] e_left;
    logic [12:0] len;
    logic [7:0]  b;
    logic [15:0] cnt_new;
    logic [15:0] sa_new;
    logic [17:0] pos_p1;
    logic        have_main, have_st, seg_end;
    result_t     main_res, st_res;
    status_e     st_code;

    b       = s1_byte_q;
    size    = (image_size_q > MaxSize) ? MaxSize : image_size_q;
    e_pos   = s1_first_q ? '0 : pos_q;
    e_phase = s1_first_q ? PhType : phase_q;
    e_last  = s1_first_q ? 1'b0 : last_q;
    e_fin   = s1_first_q ? 1'b0 : finished_q;
    e_left  = s1_first_q ? '0 : left_q;
    len     = cnt_q[12:0];
    pos_p1  = {1'b0, e_pos} + 18'd1;
    cnt_new = {cnt_q[15:8], b};
    sa_new  = {seg_addr_q[15:8], b};

    have_main = 1'b0;
    have_st   = 1'b0;
    seg_end   = 1'b0;
    st_code   = StOk;
    main_res  = '0;

    pos_d      = e_pos;
    phase_d    = e_phase;
    vendor_d   = vendor_q;
    product_d  = product_q;
    device_d   = device_q;
    cnt_d      = cnt_q;
    seg_addr_d = seg_addr_q;
    left_d     = e_left;
    last_d     = e_last;

    if (!e_fin) begin
      pos_d = pos_p1[16:0];
      unique case (e_phase) inside
        PhType: begin
          if (size == '0) begin
            have_st = 1'b1;
            st_code = StShortImage;
          end else if (b != TypeC0 && b != TypeC2) begin
            have_st = 1'b1;
            st_code = StBadType;
          end else if (size < 17'(HdrBytes)) begin
            have_st = 1'b1;
            st_code = StShortImage;
          end else begin
            phase_d = (b == TypeC2) ? PhHdrC2 : PhHdrC0;
          end
        end
        PhHdrC0, PhHdrC2: begin
          unique case (e_pos[2:0])
            3'd1: vendor_d  = {vendor_q[15:8], b};
            3'd2: vendor_d  = {b, vendor_q[7:0]};
            3'd3: product_d = {product_q[15:8], b};
            3'd4: product_d = {b, product_q[7:0]};
            3'd5: device_d  = {device_q[15:8], b};
            3'd6: device_d  = {b, device_q[7:0]};
            default: begin
              have_main           = 1'b1;
              main_res.kind       = KindHeader;
              main_res.value      = b;
              main_res.vendor_id  = vendor_q;
              main_res.product_id = product_q;
              main_res.device_id  = device_q;
              if (e_phase == PhHdrC0) begin
                have_st = 1'b1;
                st_code = StHeaderOnly;
              end else if (size <= 17'(HdrBytes)) begin
                have_st = 1'b1;
                st_code = StPastImage;
              end else begin
                phase_d = PhCntHi;
              end
            end
          endcase
        end
        PhCntHi: begin
          if (e_pos >= size) begin
            have_st = 1'b1;
            st_code = StPastImage;
          end else if ({1'b0, e_pos} + 18'(SegHdrBytes) > {1'b0, size}) begin
            have_st = 1'b1;
            st_code = StOverrun;
          end else begin
            cnt_d   = {b, 8'h00};
            phase_d = PhCntLo;
          end
        end
        PhCntLo: begin
          cnt_d = cnt_new;
          if ((cnt_new & CntRsvdMask) != '0) begin
            have_st = 1'b1;
            st_code = StRsvdBits;
          end else begin
            last_d  = ((cnt_new & CntLastMask) != '0);
            phase_d = PhAdrHi;
          end
        end
        PhAdrHi: begin
          seg_addr_d = {b, 8'h00};
          phase_d    = PhAdrLo;
        end
        PhAdrLo: begin
          seg_addr_d = sa_new;
          // Segment starts three bytes back; its end must fit in the image.
          if ({1'b0, pos_p1} + 19'(len) > {2'b00, size}) begin
            have_st = 1'b1;
            st_code = StOverrun;
          end else begin
            have_main               = 1'b1;
            main_res.kind           = KindSegment;
            main_res.address        = sa_new;
            main_res.segment_length = len;
            main_res.final_segment  = e_last;
            left_d                  = len;
            if (len == '0) begin
              seg_end = 1'b1;
            end else begin
              phase_d = PhPayload;
            end
          end
        end
        default: begin
          have_main               = 1'b1;
          main_res.kind           = KindPayload;
          main_res.address        = seg_addr_q + 16'(len - e_left);
          main_res.value          = b;
          main_res.segment_length = len;
          main_res.final_segment  = e_last;
          if (e_left != '0) begin
            left_d = e_left - 13'd1;
          end
          if (e_left <= 13'd1) begin
            seg_end = 1'b1;
          end
        end
      endcase

      // Close a segment: the last one ends the parse, otherwise the next
      // segment must start inside the image.
      if (seg_end) begin
        if (e_last) begin
          have_st = 1'b1;
          st_code = StOk;
        end else if (pos_p1 >= {1'b0, size}) begin
          have_st = 1'b1;
          st_code = StPastImage;
        end else begin
          phase_d = PhCntHi;
        end
      end
    end

    finished_d = e_fin || have_st;

    st_res        = '0;
    st_res.kind   = KindStatus;
    st_res.status = st_code;

    res0    = '0;
    res1    = '0;
    res_cnt = 2'd0;
    if (have_main) begin
      res0    = main_res;
      res_cnt = 2'd1;
      if (have_st) begin
        res1    = st_res;
        res_cnt = 2'd2;
      end
    end else if (have_st) begin
      res0    = st_res;
      res_cnt = 2'd1;
    end
    if (res_cnt == 2'd2) begin
      res1.end_of_run = 1'b1;
    end else begin
      res0.end_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      phase_q    <= PhType;
      vendor_q   <= '0;
      product_q  <= '0;
      device_q   <= '0;
      cnt_q      <= '0;
      seg_addr_q <= '0;
      left_q     <= '0;
      last_q     <= 1'b0;
      finished_q <= 1'b1;
    end else if (proc) begin
      pos_q      <= pos_d;
      phase_q    <= phase_d;
      vendor_q   <= vendor_d;
      product_q  <= product_d;
      device_q   <= device_d;
      cnt_q      <= cnt_d;
      seg_addr_q <= seg_addr_d;
      left_q     <= left_d;
      last_q     <= last_d;
      finished_q <= finished_d;
    end
  end

  uebip_res_fifo #(
    .Depth(ResDepth)
  ) u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cnt_i   (proc ? res_cnt : 2'd0),
    .wr_data0_i (res0),
    .wr_data1_i (res1),
    .room_o     (room),
    .rd_valid_o (out_valid_o),
    .rd_ready_i (out_ready_i),
    .rd_data_o  (rd_data)
  );

  assign kind_o           = rd_data.kind;
  assign address_o        = rd_data.address;
  assign value_o          = rd_data.value;
  assign vendor_id_o      = rd_data.vendor_id;
  assign product_id_o     = rd_data.product_id;
  assign device_id_o      = rd_data.device_id;
  assign segment_length_o = rd_data.segment_length;
  assign final_segment_o  = rd_data.final_segment;
  assign status_o         = rd_data.status;
  assign end_of_run_o     = rd_data.end_of_run;

  // A live parse in the payload phase always has bytes left; a parse that
  // ended on its last payload byte keeps the phase with nothing left.
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!finished_q && phase_q == PhPayload) |-> (left_q != '0))
    else $error("payload phase with no bytes left");

  // A status word always ends the parse.
  a_status_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && res_cnt != 2'd0 &&
     ((res_cnt == 2'd1 && res0.kind == KindStatus) ||
      (res_cnt == 2'd2 && res1.kind == KindStatus))) |=> finished_q)
    else $error("status reported but parse not finished");

  // A live parse waiting for its type byte sits at offset zero.
  a_type_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!finished_q && phase_q == PhType) |-> (pos_q == '0))
    else $error("type byte expected away from offset zero");

endmodule

// File: tb/sv/usb_boot_eeprom_image_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_boot_eeprom_image_parser_test
// Self-checking bench for the C0/C2 boot EEPROM image parser. A short table
// of directed bytes covers the type checks, the header, a wrapping payload
// address, a restart and the reserved count bits. Random images follow:
// mostly well-formed C2 images with random IDs, segments and addresses, plus
// C0 images, bad types, cut-off streams and image sizes that do not match.
// Result words are compared against an in-bench model of the parser or a typed-in value.
// ----------------------------------------------------------------------------
module usb_boot_eeprom_image_parser_test;
  import uebip_pkg::*;

  // Random images are sent until at least this many bytes follow the table.
  localparam int unsigned RandomBytes = 1400;
  // A byte is parsed from the input register after it is taken, and its results
  // pass through the result queue; this wait covers a byte with no result.
  localparam int unsigned SettleCycles = 4;
  // Upper bound on the final drain, in cycles.
  localparam int unsigned DrainLimit = 5000;

  // How a directed row is checked: by the model, or by a value typed in.
  typedef enum {UsePredictor, TypedNone, TypedStatus} check_mode_e;

  typedef struct {
    logic        cfg_write;
    logic [16:0] size;
    logic [7:0]  data;
    logic        first;
    check_mode_e mode;
    status_e     st;
  } stim_row_t;

  localparam int NumRows = 34;

  logic        clk_i;
  logic        rst_ni;
  logic        image_size_we_i;
  logic [16:0] image_size_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        first_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  kind_o;
  logic [15:0] address_o;
  logic [7:0]  value_o;
  logic [15:0] vendor_id_o;
  logic [15:0] product_id_o;
  logic [15:0] device_id_o;
  logic [12:0] segment_length_o;
  logic        final_segment_o;
  logic [2:0]  status_o;
  logic        end_of_run_o;

  usb_boot_eeprom_image_parser dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .image_size_we_i  (image_size_we_i),
    .image_size_i     (image_size_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .first_byte_i     (first_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .address_o        (address_o),
    .value_o          (value_o),
    .vendor_id_o      (vendor_id_o),
    .product_id_o     (product_id_o),
    .device_id_o      (device_id_o),
    .segment_length_o (segment_length_o),
    .final_segment_o  (final_segment_o),
    .status_o         (status_o),
    .end_of_run_o     (end_of_run_o)
  );

  // Clock: 20 ns period.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Parser model. It keeps its own copy of the image size register and of
  // the parse state, and turns each accepted byte into zero, one or two
  // expected result words.
  // --------------------------------------------------------------------------
  logic [16:0] model_image_size = '0;
  logic [16:0] model_pos        = '0;
  logic [2:0]  model_phase      = PhType;
  logic [15:0] model_vendor     = '0;
  logic [15:0] model_product    = '0;
  logic [15:0] model_device     = '0;
  logic [15:0] model_count      = '0;
  logic [15:0] model_seg_addr   = '0;
  logic [12:0] model_pay_left   = '0;
  logic        model_last_seg   = 1'b0;
  // After reset the parser waits for a first byte.
  logic        model_done       = 1'b1;

  // Results of the byte just parsed.
  result_t step_words [2];
  int      step_count;

  // Result words still owed by the block, oldest first.
  result_t expected_results [$];

  int error_count = 0;

  function automatic result_t status_word(status_e st);
    result_t r;
    r = '0;
    r.kind       = KindStatus;
    r.status     = st;
    r.end_of_run = 1'b1;
    return r;
  endfunction

  function automatic void emit_word(result_t r);
    step_words[step_count] = r;
    step_count++;
  endfunction

  // A status word always closes the parse.
  function automatic void emit_status(status_e st);
    emit_word(status_word(st));
    model_done = 1'b1;
  endfunction

  // Called when a segment's payload is complete; next_offs is where the
  // following segment would begin.
  function automatic void close_segment(int unsigned next_offs, int unsigned size);
    if (model_last_seg) begin
      emit_status(StOk);
    end else if (next_offs >= size) begin
      emit_status(StPastImage);
    end else begin
      model_phase = PhCntHi;
    end
  endfunction

  function automatic void parse_image_byte(logic [7:0] d, logic first);
    int unsigned size;
    int unsigned pos;
    logic [15:0] len;
    result_t     r;
    step_count = 0;
    if (first) begin
      model_pos      = '0;
      model_phase    = PhType;
      model_done     = 1'b0;
      model_last_seg = 1'b0;
      model_pay_left = '0;
    end
    if (model_done) return;

    // Sizes above the parser's maximum are clamped.
    size = (model_image_size > MaxImageBytes) ? MaxImageBytes : model_image_size;
    pos  = model_pos;
    len  = model_count & 16'h7FFF;

    case (model_phase)
      PhType: begin
        if (size == 0) begin
          emit_status(StShortImage);
        end else if (d != TypeC0 && d != TypeC2) begin
          emit_status(StBadType);
        end else if (size < HdrBytes) begin
          emit_status(StShortImage);
        end else begin
          model_phase = (d == TypeC2) ? PhHdrC2 : PhHdrC0;
        end
      end
      PhHdrC0, PhHdrC2: begin
        case (pos[2:0])
          3'd1: model_vendor[7:0]   = d;
          3'd2: model_vendor[15:8]  = d;
          3'd3: model_product[7:0]  = d;
          3'd4: model_product[15:8] = d;
          3'd5: model_device[7:0]   = d;
          3'd6: model_device[15:8]  = d;
          default: begin
            // The config byte completes the header.
            r = '0;
            r.kind       = KindHeader;
            r.value      = d;
            r.vendor_id  = model_vendor;
            r.product_id = model_product;
            r.device_id  = model_device;
            emit_word(r);
            if (model_phase == PhHdrC0) begin
              emit_status(StHeaderOnly);
            end else if (HdrBytes >= size) begin
              emit_status(StPastImage);
            end else begin
              model_phase = PhCntHi;
            end
          end
        endcase
      end
      PhCntHi: begin
        if (pos >= size) begin
          emit_status(StPastImage);
        end else if (pos + SegHdrBytes > size) begin
          emit_status(StOverrun);
        end else begin
          model_count = {d, 8'h00};
          model_phase = PhCntLo;
        end
      end
      PhCntLo: begin
        model_count[7:0] = d;
        if ((model_count & CntRsvdMask) != 0) begin
          emit_status(StRsvdBits);
        end else begin
          model_last_seg = model_count[15];
          model_phase    = PhAdrHi;
        end
      end
      PhAdrHi: begin
        model_seg_addr = {d, 8'h00};
        model_phase    = PhAdrLo;
      end
      PhAdrLo: begin
        model_seg_addr[7:0] = d;
        if ((pos - 3) + len + SegHdrBytes > size) begin
          emit_status(StOverrun);
        end else begin
          r = '0;
          r.kind           = KindSegment;
          r.address        = model_seg_addr;
          r.segment_length = len[12:0];
          r.final_segment  = model_last_seg;
          emit_word(r);
          model_pay_left = len[12:0];
          if (model_pay_left == 0) begin
            close_segment(pos + 1, size);
          end else begin
            model_phase = PhPayload;
          end
        end
      end
      default: begin
        r = '0;
        r.kind           = KindPayload;
        r.address        = model_seg_addr + (len - {3'b000, model_pay_left});
        r.value          = d;
        r.segment_length = len[12:0];
        r.final_segment  = model_last_seg;
        emit_word(r);
        if (model_pay_left > 0) model_pay_left--;
        if (model_pay_left == 0) close_segment(pos + 1, size);
      end
    endcase

    model_pos = 17'(pos + 1);
    if (step_count > 0) step_words[step_count - 1].end_of_run = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking. Outputs are sampled at the rising edge, before the
  // block's registers update.
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: kind 0x%0h status 0x%0h",
               kind_o, status_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("address", want.address, address_o);
        check_field("value", want.value, value_o);
        check_field("vendor_id", want.vendor_id, vendor_id_o);
        check_field("product_id", want.product_id, product_id_o);
        check_field("device_id", want.device_id, device_id_o);
        check_field("segment_length", want.segment_length, segment_length_o);
        check_field("final_segment", want.final_segment, final_segment_o);
        check_field("status", want.status, status_o);
        check_field("end_of_run", want.end_of_run, end_of_run_o);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. It picks a new stall mode whenever its timer runs out: always ready,
  // mostly ready, mostly stalled, or a fixed one-in-four stall.
  // --------------------------------------------------------------------------
  int unsigned stall_mode  = 0;
  int unsigned stall_timer = 0;
  int unsigned stall_phase = 0;

  always @(negedge clk_i) begin
    if (stall_timer == 0) begin
      stall_mode  = $urandom_range(0, 3);
      stall_timer = $urandom_range(20, 120);
    end else begin
      stall_timer--;
    end
    stall_phase++;
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 3) != 0);
      2:       out_ready_i <= ($urandom_range(0, 2) == 0);
      default: out_ready_i <= ((stall_phase % 4) != 3);
    endcase
  end

  // --------------------------------------------------------------------------
  // Sender. Bytes go out in bursts of random length; between bursts valid may
  // drop low for a random gap. Every task below starts and ends at a
  // falling edge.
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;

  task automatic send_byte(logic [7:0] d, logic first, check_mode_e mode, status_e st);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= d;
    first_byte_i <= first;
    do @(posedge clk_i); while (!in_ready_o);
    // The word was taken at this edge; the model runs now so that its state
    // stays in step even when a directed row types its result in.
    parse_image_byte(d, first);
    case (mode)
      UsePredictor: begin
        for (int i = 0; i < step_count; i++) expected_results.push_back(step_words[i]);
      end
      TypedStatus: expected_results.push_back(status_word(st));
      default: ;
    endcase
    burst_left--;
    @(negedge clk_i);
  endtask

  // Wait until every expected word has arrived, then SettleCycles more for a
  // byte that may still be in flight without giving a result.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_image_size(logic [16:0] v);
    wait_idle();
    image_size_we_i <= 1'b1;
    image_size_i    <= v;
    @(negedge clk_i);
    image_size_we_i <= 1'b0;
    model_image_size = v;
  endtask

  // --------------------------------------------------------------------------
  // Random images. Most are well-formed C2 images with random content; some
  // are C0 images, bad types, images with reserved count bits, streams that
  // are cut off by a restart, and image sizes that are too small, too large
  // or at the register's extremes.
  // --------------------------------------------------------------------------
  int unsigned random_bytes_sent = 0;

  task automatic run_random_image();
    logic [7:0]  img [$];
    logic [7:0]  type_byte;
    logic [15:0] count;
    logic [15:0] addr;
    int unsigned sel;
    int unsigned nseg;
    int unsigned npay;
    int unsigned total;
    int unsigned cut;
    int unsigned size_val;
    logic        stop;

    sel = $urandom_range(0, 99);
    if (sel < 75) type_byte = TypeC2;
    else if (sel < 88) type_byte = TypeC0;
    else type_byte = 8'($urandom);
    img.push_back(type_byte);
    for (int i = 0; i < 7; i++) img.push_back(8'($urandom));

    if (type_byte == TypeC2) begin
      nseg = $urandom_range(1, 4);
      stop = 1'b0;
      for (int s = 0; s < nseg && !stop; s++) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
          count = 16'($urandom_range(0, 10));
        end else begin
          // Any count the flag-free bits allow; large ones overrun the image.
          count = 16'($urandom) & 16'h13FF;
        end
        if (s == nseg - 1 && $urandom_range(0, 9) != 0) count |= CntLastMask;
        // Occasionally set one of the reserved count bits.
        if ($urandom_range(0, 19) == 0) begin
          case ($urandom_range(0, 3))
            0:       count |= 16'h4000;
            1:       count |= 16'h2000;
            2:       count |= 16'h0800;
            default: count |= 16'h0400;
          endcase
        end
        sel = $urandom_range(0, 9);
        if (sel < 5) addr = 16'($urandom);
        else if (sel < 8) addr = 16'hFFF8 + 16'($urandom_range(0, 7));
        else addr = 16'($urandom_range(0, 255));
        img.push_back(count[15:8]);
        img.push_back(count[7:0]);
        img.push_back(addr[15:8]);
        img.push_back(addr[7:0]);
        npay = count & 16'h13FF;
        if (npay > 16) begin
          // Only part of a long payload is sent; the stream ends here.
          npay = $urandom_range(0, 16);
          stop = 1'b1;
        end
        for (int i = 0; i < npay; i++) img.push_back(8'($urandom));
      end
    end

    total = img.size();
    sel   = $urandom_range(0, 99);
    if (sel < 55) size_val = total;
    else if (sel < 67) size_val = (total > 6) ? total - $urandom_range(1, 6) : 0;
    else if (sel < 79) size_val = total + $urandom_range(1, 8);
    else if (sel < 83) size_val = 0;
    else if (sel < 88) size_val = $urandom_range(1, 8);
    else if (sel < 94) size_val = MaxImageBytes;
    else size_val = 17'h1FFFF;
    if ($urandom_range(0, 9) < 8) write_image_size(17'(size_val));

    // Sometimes the image is cut short and the next one restarts the parser.
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total) : total;
    for (int i = 0; i < cut; i++) begin
      send_byte(img[i], (i == 0), UsePredictor, StOk);
      random_bytes_sent++;
    end
    // A stray first byte in the middle of nowhere.
    if ($urandom_range(0, 19) == 0) begin
      send_byte(8'($urandom), 1'b1, UsePredictor, StOk);
      random_bytes_sent++;
    end
    // Trailing bytes without the first flag; usually dropped by the block.
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, UsePredictor, StOk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table. Rows with a typed status or no result are the ones whose
  // outcome is plain by hand from the rows before them.
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [NumRows];

  initial begin
    directed_rows = '{
      // Nothing has started yet: the byte is dropped.
      '{1'b0, 17'd0, 8'h5A, 1'b0, TypedNone, StOk},
      // The image size resets to zero, so any type byte sees an empty image.
      '{1'b0, 17'd0, TypeC2, 1'b1, TypedStatus, StShortImage},
      '{1'b1, 17'd5, 8'h00, 1'b0, UsePredictor, StOk},
      // A valid type with an image shorter than the header.
      '{1'b0, 17'd0, TypeC0, 1'b1, TypedStatus, StShortImage},
      // Bad type byte at the low extreme.
      '{1'b0, 17'd0, 8'h00, 1'b1, TypedStatus, StBadType},
      // The parse has finished: another byte is dropped.
      '{1'b0, 17'd0, 8'hA5, 1'b0, TypedNone, StOk},
      '{1'b1, 17'd12, 8'h00, 1'b0, UsePredictor, StOk},
      // A C2 image dropped after two bytes by a restart with a C0 image.
      '{1'b0, 17'd0, TypeC2, 1'b1, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'hFF, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, TypeC0, 1'b1, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'h00, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'h00, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'h00, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'h00, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'h00, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'h00, 1'b0, UsePredictor, StOk},
      // Config byte: header word, then the header-only status.
      '{1'b0, 17'd0, 8'hFF, 1'b0, UsePredictor, StOk},
      // Size above the maximum, clamped by the block.
      '{1'b1, 17'h1FFFF, 8'h00, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, TypeC2, 1'b1, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'hFF, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'hFF, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'hFF, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'hFF, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'hFF, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'hFF, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'hFF, 1'b0, UsePredictor, StOk},
      // Two-byte segment loaded at the top of the address space; the second
      // byte's address wraps to zero.
      '{1'b0, 17'd0, 8'h00, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'h02, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'hFF, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'hFF, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'h3C, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'h5A, 1'b0, UsePredictor, StOk},
      // Next segment count has reserved bits set.
      '{1'b0, 17'd0, 8'hEC, 1'b0, UsePredictor, StOk},
      '{1'b0, 17'd0, 8'h00, 1'b0, TypedStatus, StRsvdBits}
    };
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, random images, drain.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned drain;
    rst_ni          = 1'b0;
    image_size_we_i = 1'b0;
    image_size_i    = '0;
    in_valid_i      = 1'b0;
    data_byte_i     = '0;
    first_byte_i    = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_write) begin
        write_image_size(directed_rows[i].size);
      end else begin
        send_byte(directed_rows[i].data, directed_rows[i].first,
                  directed_rows[i].mode, directed_rows[i].st);
      end
    end

    // The register is written with zero and with the parser's maximum once more
    // before the random images move it around.
    write_image_size(17'd0);
    send_byte(TypeC0, 1'b1, UsePredictor, StOk);
    write_image_size(17'(MaxImageBytes));

    while (random_bytes_sent < RandomBytes) run_random_image();

    // Drain: wait for every owed word, with a bound, then watch a little
    // longer for words that should not come.
    in_valid_i <= 1'b0;
    drain = 0;
    while (expected_results.size() != 0 && drain < DrainLimit) begin
      @(negedge clk_i);
      drain++;
    end
    if (expected_results.size() != 0) begin
      $error("%0d expected result words never arrived", expected_results.size());
      error_count++;
    end
    repeat (4 * SettleCycles) @(negedge clk_i);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: the slowest correct run is far shorter than this.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
hdl/uebip_pkg.sv
hdl/uebip_res_fifo.sv
hdl/usb_boot_eeprom_image_parser.sv
tb/sv/usb_boot_eeprom_image_parser_test.sv
